/* src/igscc_pkg.sv */
package igscc_pkg;

    localparam int LIT_W    = 6;
    localparam int MAX_LITS = 64;
    localparam int ND_W     = 7;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_FIND   = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_MEMBER  = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    // One depth-first frame: vertex, next neighbor to scan, Tarjan numbers and
    // the member stack position at which the vertex was pushed.
    typedef struct packed {
        logic [LIT_W-1:0] v;
        logic [ND_W-1:0]  nx;
        logic [ND_W-1:0]  low;
        logic [ND_W-1:0]  disc;
        logic [LIT_W-1:0] sp;
    } t_frame;

endpackage

/* src/igscc_cmd_if.sv */
interface igscc_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [5:0] first_var;
    logic       first_negated;
    logic [5:0] second_var;
    logic       second_negated;

    modport source(output valid, action, first_var, first_negated, second_var,
                   second_negated, input ready);
    modport sink(input valid, action, first_var, first_negated, second_var,
                 second_negated, output ready);
endinterface

/* src/igscc_res_if.sv */
interface igscc_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] member_var;
    logic       member_negated;
    logic [4:0] group_index;
    logic       group_end;
    logic       run_end;

    modport source(output valid, status, member_var, member_negated, group_index,
                   group_end, run_end, input ready);
    modport sink(input valid, status, member_var, member_negated, group_index,
                 group_end, run_end, output ready);
endinterface

/* src/igscc_ram.sv */
module igscc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* src/igscc_lowbit.sv */
module igscc_lowbit (
    input  logic [igscc_pkg::MAX_LITS-1:0] i_row,
    output logic                           o_found,
    output logic [igscc_pkg::LIT_W-1:0]    o_idx
);
    import igscc_pkg::*;

    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int i = MAX_LITS - 1; i >= 0; i--) begin
            if (i_row[i]) begin
                o_found = 1'b1;
                o_idx   = LIT_W'(i);
            end
        end
    end
endmodule

/* src/implication_graph_scc_finder.sv */
// Clause add or remove: the two complement rows are each read and rewritten, then the
// result is registered in S_RESP; an invalid request goes straight to S_RESP. Search:
// each literal is entered, its row loaded and scanned; an edge to a vertex still on the
// stack adds S_DISC, each member is read and emitted, and a return pops a parent frame.
// One transaction is taken at a time. Synchronous active-low reset leaves the
// graph empty through per-row valid flags; no memory clearing pass is needed.
module implication_graph_scc_finder #(
    parameter int NUM_VARS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    igscc_cmd_if.sink         i_cmd,
    igscc_res_if.source       o_res
);
    import igscc_pkg::*;

    localparam int NLITS = 2 * NUM_VARS;
    localparam logic [MAX_LITS-1:0] LIT_MASK =
        (NLITS >= MAX_LITS) ? {MAX_LITS{1'b1}} : MAX_LITS'((65'd1 << NLITS) - 65'd1);

    typedef enum logic [3:0] {
        S_IDLE, S_URD1, S_UWR1, S_URD2, S_UWR2, S_RESP, S_ROOT, S_ENTER,
        S_LOAD, S_SCAN, S_DISC, S_MREAD, S_MEMIT, S_RET, S_POP, S_FIN
    } t_state;

    t_state r_state;

    logic [MAX_LITS-1:0] r_vld, r_visit, r_onstk, r_row;
    logic [LIT_W-1:0]    r_ua, r_ub, r_v, r_sp;
    logic                r_add;
    logic [1:0]          r_resp;
    logic [ND_W-1:0]     r_root, r_csp, r_msp, r_nd, r_nx, r_low, r_disc;
    logic [4:0]          r_groups;
    logic                r_pvld, r_p_gend;
    logic [LIT_W-1:0]    r_p_lit;
    logic [4:0]          r_p_grp;

    logic       r_ovld, r_o_neg, r_o_gend, r_o_rend;
    logic [1:0] r_o_status;
    logic [5:0] r_o_var;
    logic [4:0] r_o_grp;

    // Memories.
    logic                adj_we, adj_re;
    logic [LIT_W-1:0]    adj_waddr, adj_raddr;
    logic [MAX_LITS-1:0] adj_wdata, adj_q, adj_row;
    logic                dsc_re;
    logic [ND_W-1:0]     dsc_q;
    logic                mst_re;
    logic [LIT_W-1:0]    mst_q;
    logic                cst_we, cst_re;
    t_frame              cst_wdata, cst_q;

    logic             lb_found;
    logic [LIT_W-1:0] lb_idx;
    logic             out_free;
    logic             va_ok, vb_ok;
    logic [LIT_W-1:0] lit_a, lit_b, upd_row;
    logic [ND_W-1:0]  count, msp_m1, csp_m1;
    logic             last_mem;

    assign out_free = !r_ovld || o_res.ready;
    assign msp_m1   = r_msp - ND_W'(1);
    assign csp_m1   = r_csp - ND_W'(1);
    assign count    = r_msp - {1'b0, r_sp};
    assign last_mem = (msp_m1 == {1'b0, r_sp});

    assign va_ok = (i_cmd.first_var != 6'd0) && (i_cmd.first_var <= 6'(NUM_VARS));
    assign vb_ok = (i_cmd.second_var != 6'd0) && (i_cmd.second_var <= 6'(NUM_VARS));
    assign lit_a = {5'(i_cmd.first_var - 6'd1), i_cmd.first_negated};
    assign lit_b = {5'(i_cmd.second_var - 6'd1), i_cmd.second_negated};

    // Row being updated by a clause: complement of one literal, edge to the other.
    assign upd_row = (r_state == S_UWR1) ? (r_ua ^ LIT_W'(1)) : (r_ub ^ LIT_W'(1));

    always_comb begin
        adj_re    = 1'b0;
        adj_raddr = r_v;
        case (r_state)
            S_URD1:  begin adj_re = 1'b1; adj_raddr = r_ua ^ LIT_W'(1); end
            S_URD2:  begin adj_re = 1'b1; adj_raddr = r_ub ^ LIT_W'(1); end
            S_ENTER: begin adj_re = 1'b1; adj_raddr = r_v; end
            S_POP:   begin adj_re = 1'b1; adj_raddr = cst_q.v; end
            default: begin adj_re = 1'b0; end
        endcase
    end

    always_comb begin
        adj_row   = r_vld[upd_row] ? adj_q : '0;
        adj_we    = (r_state == S_UWR1) || (r_state == S_UWR2);
        adj_waddr = upd_row;
        if (r_state == S_UWR1) begin
            adj_wdata = r_add ? (adj_row | (MAX_LITS'(1) << r_ub))
                              : (adj_row & ~(MAX_LITS'(1) << r_ub));
        end else begin
            adj_wdata = r_add ? (adj_row | (MAX_LITS'(1) << r_ua))
                              : (adj_row & ~(MAX_LITS'(1) << r_ua));
        end
    end

    assign dsc_re = (r_state == S_SCAN) && lb_found;
    assign mst_re = (r_state == S_MREAD);
    assign cst_re = (r_state == S_RET);
    assign cst_we = (r_state == S_SCAN) && lb_found && !r_visit[lb_idx];
    assign cst_wdata = '{v: r_v, nx: ND_W'(lb_idx) + ND_W'(1), low: r_low,
                         disc: r_disc, sp: r_sp};

    igscc_ram #(.WIDTH(MAX_LITS), .DEPTH(MAX_LITS)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_re(adj_re), .i_raddr(adj_raddr), .o_rdata(adj_q));

    igscc_ram #(.WIDTH(ND_W), .DEPTH(MAX_LITS)) u_disc (
        .i_clk(i_clk), .i_we(r_state == S_ENTER), .i_waddr(r_v), .i_wdata(r_nd),
        .i_re(dsc_re), .i_raddr(lb_idx), .o_rdata(dsc_q));

    igscc_ram #(.WIDTH(LIT_W), .DEPTH(MAX_LITS)) u_mstk (
        .i_clk(i_clk), .i_we(r_state == S_ENTER), .i_waddr(r_msp[LIT_W-1:0]),
        .i_wdata(r_v), .i_re(mst_re), .i_raddr(msp_m1[LIT_W-1:0]), .o_rdata(mst_q));

    igscc_ram #(.WIDTH($bits(t_frame)), .DEPTH(MAX_LITS)) u_cstk (
        .i_clk(i_clk), .i_we(cst_we), .i_waddr(r_csp[LIT_W-1:0]), .i_wdata(cst_wdata),
        .i_re(cst_re), .i_raddr(csp_m1[LIT_W-1:0]), .o_rdata(cst_q));

    igscc_lowbit u_lowbit (.i_row(r_row), .o_found(lb_found), .o_idx(lb_idx));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_pvld  <= 1'b0;
            r_vld   <= '0;
            r_visit <= '0;
            r_onstk <= '0;
            r_nd    <= '0;
        end else begin
            if (o_res.ready) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_ua  <= lit_a;
                        r_ub  <= lit_b;
                        r_add <= (i_cmd.action == ACT_ADD);
                        if (i_cmd.action == ACT_FIND) begin
                            r_visit  <= '0;
                            r_onstk  <= '0;
                            r_nd     <= '0;
                            r_root   <= '0;
                            r_csp    <= '0;
                            r_msp    <= '0;
                            r_groups <= '0;
                            r_pvld   <= 1'b0;
                            r_state  <= S_ROOT;
                        end else if (i_cmd.action == ACT_ADD || i_cmd.action == ACT_REMOVE) begin
                            if (va_ok && vb_ok) begin
                                r_state <= S_URD1;
                            end else begin
                                r_resp  <= ST_INVALID;
                                r_state <= S_RESP;
                            end
                        end else begin
                            r_resp  <= ST_INVALID;
                            r_state <= S_RESP;
                        end
                    end
                end
                S_URD1: r_state <= S_UWR1;
                S_UWR1: begin
                    r_vld[upd_row] <= 1'b1;
                    r_state        <= S_URD2;
                end
                S_URD2: r_state <= S_UWR2;
                S_UWR2: begin
                    r_vld[upd_row] <= 1'b1;
                    r_resp         <= ST_DONE;
                    r_state        <= S_RESP;
                end
                S_RESP: begin
                    if (out_free) begin
                        r_ovld     <= 1'b1;
                        r_o_status <= r_resp;
                        r_o_var    <= '0;
                        r_o_neg    <= 1'b0;
                        r_o_grp    <= '0;
                        r_o_gend   <= 1'b0;
                        r_o_rend   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_ROOT: begin
                    if (r_root >= ND_W'(NLITS)) begin
                        r_state <= S_FIN;
                    end else if (r_visit[r_root[LIT_W-1:0]]) begin
                        r_root <= r_root + ND_W'(1);
                    end else begin
                        r_v     <= r_root[LIT_W-1:0];
                        r_state <= S_ENTER;
                    end
                end
                S_ENTER: begin
                    r_disc       <= r_nd;
                    r_low        <= r_nd;
                    r_nd         <= r_nd + ND_W'(1);
                    r_visit[r_v] <= 1'b1;
                    r_onstk[r_v] <= 1'b1;
                    r_sp         <= r_msp[LIT_W-1:0];
                    r_msp        <= r_msp + ND_W'(1);
                    r_nx         <= '0;
                    r_state      <= S_LOAD;
                end
                S_LOAD: begin
                    r_row   <= (r_vld[r_v] ? adj_q : '0) & LIT_MASK
                               & ({MAX_LITS{1'b1}} << r_nx);
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (lb_found) begin
                        r_row[lb_idx] <= 1'b0;
                        if (!r_visit[lb_idx]) begin
                            r_csp   <= r_csp + ND_W'(1);
                            r_v     <= lb_idx;
                            r_state <= S_ENTER;
                        end else if (r_onstk[lb_idx]) begin
                            r_state <= S_DISC;
                        end
                    end else if (r_low == r_disc) begin
                        if (count >= ND_W'(2)) begin
                            r_state <= S_MREAD;
                        end else begin
                            // A single-literal component is dropped silently.
                            r_msp        <= msp_m1;
                            r_onstk[r_v] <= 1'b0;
                            r_state      <= S_RET;
                        end
                    end else begin
                        r_state <= S_RET;
                    end
                end
                S_DISC: begin
                    if (dsc_q < r_low) begin
                        r_low <= dsc_q;
                    end
                    r_state <= S_SCAN;
                end
                S_MREAD: r_state <= S_MEMIT;
                S_MEMIT: begin
                    // The newest member is held back so that run_end can be
                    // marked on whichever member turns out to be the last.
                    if (!r_pvld || out_free) begin
                        if (r_pvld) begin
                            r_ovld     <= 1'b1;
                            r_o_status <= ST_MEMBER;
                            r_o_var    <= 6'(r_p_lit[LIT_W-1:1]) + 6'd1;
                            r_o_neg    <= r_p_lit[0];
                            r_o_grp    <= r_p_grp;
                            r_o_gend   <= r_p_gend;
                            r_o_rend   <= 1'b0;
                        end
                        r_pvld         <= 1'b1;
                        r_p_lit        <= mst_q;
                        r_p_grp        <= r_groups;
                        r_p_gend       <= last_mem;
                        r_onstk[mst_q] <= 1'b0;
                        r_msp          <= msp_m1;
                        if (last_mem) begin
                            r_groups <= r_groups + 5'd1;
                            r_state  <= S_RET;
                        end else begin
                            r_state <= S_MREAD;
                        end
                    end
                end
                S_RET: begin
                    if (r_csp == '0) begin
                        r_root  <= r_root + ND_W'(1);
                        r_state <= S_ROOT;
                    end else begin
                        r_csp   <= csp_m1;
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    r_v     <= cst_q.v;
                    r_nx    <= cst_q.nx;
                    r_disc  <= cst_q.disc;
                    r_sp    <= cst_q.sp;
                    r_low   <= (r_low < cst_q.low) ? r_low : cst_q.low;
                    r_state <= S_LOAD;
                end
                S_FIN: begin
                    if (r_pvld) begin
                        if (out_free) begin
                            r_ovld     <= 1'b1;
                            r_o_status <= ST_MEMBER;
                            r_o_var    <= 6'(r_p_lit[LIT_W-1:1]) + 6'd1;
                            r_o_neg    <= r_p_lit[0];
                            r_o_grp    <= r_p_grp;
                            r_o_gend   <= r_p_gend;
                            r_o_rend   <= 1'b1;
                            r_pvld     <= 1'b0;
                            r_state    <= S_IDLE;
                        end
                    end else begin
                        r_resp  <= ST_NONE;
                        r_state <= S_RESP;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_cmd.ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_ovld;
    assign o_res.status         = r_o_status;
    assign o_res.member_var     = r_o_var;
    assign o_res.member_negated = r_o_neg;
    assign o_res.group_index    = r_o_grp;
    assign o_res.group_end      = r_o_gend;
    assign o_res.run_end        = r_o_rend;
endmodule
